// ===== hw/rtl/cpvs_pkg.sv =====
// Shared types, constants and helper functions for the PCG64 value source.
package cpvs_pkg;

  // PCG64 128-bit LCG multiplier and increment
  localparam logic [127:0] LCG_MULT = {64'h2360ed051fc65da4, 64'h4385df649fccf645};
  localparam logic [127:0] LCG_INC  = {64'h5851f42d4c957f2d, 64'h14057b7ef767814f};

  localparam logic [3:0] WORD_BYTES = 4'd8;

  // Instruction codes (control byte mod 6)
  localparam logic [2:0] CODE_DATA     = 3'd0;
  localparam logic [2:0] CODE_GEN      = 3'd1;
  localparam logic [2:0] CODE_ZERO     = 3'd2;
  localparam logic [2:0] CODE_ONES     = 3'd3;
  localparam logic [2:0] CODE_HALF     = 3'd4;
  localparam logic [2:0] CODE_DATA_ALT = 3'd5;

  localparam logic [63:0] VALUE_HALF = {1'b0, {63{1'b1}}};

  // x mod 6 for 8-bit x: quotient by reciprocal multiply, then one subtract
  localparam logic [7:0]  CODE_COUNT = 8'd6;
  localparam logic [15:0] MOD6_RECIP = 16'd171;
  localparam int unsigned MOD6_SHIFT = 10;

  typedef struct packed {
    logic [7:0]  cmd_byte;
    logic        control_present;
    logic [63:0] data_bytes;
    logic [3:0]  data_available;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  bytes_taken;
    logic        from_generator;
  } rsp_t;

  // Jump-ahead selector: state advanced by 2, 3 or 4 LCG steps
  typedef enum logic [1:0] {
    JUMP_2,
    JUMP_3,
    JUMP_4
  } jump_sel_e;

  // LCG_MULT ** n mod 2^128 (elaboration only)
  function automatic logic [127:0] lcg_mult_pow(int unsigned n);
    logic [127:0] r;
    r = 128'd1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * LCG_MULT;
    end
    return r;
  endfunction

  // Additive term of n LCG steps: lcg^n(0) (elaboration only)
  function automatic logic [127:0] lcg_offset(int unsigned n);
    logic [127:0] r;
    r = '0;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * LCG_MULT + LCG_INC;
    end
    return r;
  endfunction

  localparam logic [127:0] JUMP2_MULT = lcg_mult_pow(2);
  localparam logic [127:0] JUMP3_MULT = lcg_mult_pow(3);
  localparam logic [127:0] JUMP4_MULT = lcg_mult_pow(4);
  localparam logic [127:0] JUMP2_INC  = lcg_offset(2);
  localparam logic [127:0] JUMP3_INC  = lcg_offset(3);
  localparam logic [127:0] JUMP4_INC  = lcg_offset(4);

  function automatic logic [127:0] jump_mult(jump_sel_e sel);
    logic [127:0] r;
    case (sel)
      JUMP_2:  r = JUMP2_MULT;
      JUMP_4:  r = JUMP4_MULT;
      default: r = JUMP3_MULT;
    endcase
    return r;
  endfunction

  function automatic logic [127:0] jump_inc(jump_sel_e sel);
    logic [127:0] r;
    case (sel)
      JUMP_2:  r = JUMP2_INC;
      JUMP_4:  r = JUMP4_INC;
      default: r = JUMP3_INC;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mod6(logic [7:0] x);
    logic [15:0] prod;
    logic [5:0]  quo;
    logic [7:0]  back;
    logic [7:0]  rem;
    prod = {8'd0, x} * MOD6_RECIP;
    quo  = prod[MOD6_SHIFT +: 6];
    back = 8'(quo) * CODE_COUNT;
    rem  = x - back;
    return rem[2:0];
  endfunction

endpackage

// ===== hw/rtl/cpvs_stream_if.sv =====
// Valid/ready stream interfaces for request and response beats.
interface cpvs_req_if;
  import cpvs_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cpvs_rsp_if;
  import cpvs_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/controlled_pcg64_value_source_core.sv =====
// Controlled PCG64 value source: request in, one 64-bit value out per beat.
//
// Usage
//   req_i  : request beats (control byte, data bytes, data count).
//   rsp_o  : one response beat per request (value, bytes_taken, from_generator).
//   seed_i / seed_we_i : seed register write; only while the block is idle.
// Throughput
//   Responses are registered. While rsp_o is ready one request per cycle is
//   sustained, generator steps included: the 128-bit LCG runs as a 3-stage
//   pipeline (partial products, column sums, final add) holding three
//   consecutive states, each advanced by three LCG steps, so a fresh state is
//   at the head every cycle a generator beat takes one.
// Reset / seed write
//   Reset (seed 0) and every seed write refill the LCG pipeline from
//   seed + increment, with req_i.ready low until the refill is done.
// Back-pressure
//   Responses go through a two-entry buffer (output register + skid). A
//   request is still taken while one response waits; req_i.ready drops only
//   when both entries are full or a refill is running.
module controlled_pcg64_value_source_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         seed_we_i,
  input  logic [63:0]  seed_i,
  cpvs_req_if.sink     req_i,
  cpvs_rsp_if.source   rsp_o
);
  import cpvs_pkg::*;

  localparam int unsigned NUM_LIMBS = 4;
  localparam int unsigned NUM_PP    = 10;   // 32x32 products with i+j <= 3
  localparam logic [1:0]  FILL_CYCLES = 2'd3;

  // ---------------------------------------------------------------------
  // Control and config registers
  // ---------------------------------------------------------------------
  logic [1:0]   fill_cnt_q, fill_cnt_d;
  logic [63:0]  seed_q;
  logic         fill_active;

  // LCG pipeline: products -> column sums -> head state
  logic [63:0]  pp_q [NUM_PP];
  logic [63:0]  pp_d [NUM_PP];
  jump_sel_e    sel_in, sel_p_q, sel_g_q;
  logic [63:0]  g0_q;
  logic [64:0]  g1_q;
  logic [65:0]  g2_q;
  logic [31:0]  g3_q;
  logic [127:0] head_q, head_d;
  logic         lcg_adv;

  logic [127:0] seed_base;
  logic [127:0] mul_in;
  logic [127:0] mul_k;
  logic [31:0]  xa [NUM_LIMBS];
  logic [31:0]  ka [NUM_LIMBS];

  // Request decode
  req_t         req;
  rsp_t         rsp_new;
  logic [2:0]   code;
  logic [3:0]   avail;
  logic [63:0]  gen_value;
  logic [63:0]  mix_word;
  logic [127:0] mix_rot;
  logic [63:0]  data_masked;
  logic         in_fire;
  logic         gen_take;

  // Response buffer
  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  rsp_t         out_q, out_d;
  rsp_t         skid_q, skid_d;
  logic         out_take;

  assign fill_active = (fill_cnt_q != 2'd0);

  // ---------------------------------------------------------------------
  // LCG pipeline input: seed base during refill, head state otherwise.
  // Refill pushes seed+inc three times with jumps 2, 3, 4 so the pipe ends
  // up holding lcg^2, lcg^3, lcg^4 of seed+inc (first output uses lcg^2).
  // ---------------------------------------------------------------------
  assign seed_base = {64'd0, seed_q} + LCG_INC;
  assign mul_in    = fill_active ? seed_base : head_q;

  always_comb begin
    case (fill_cnt_q)
      2'd3:    sel_in = JUMP_2;
      2'd2:    sel_in = JUMP_3;
      2'd1:    sel_in = JUMP_4;
      default: sel_in = JUMP_3;
    endcase
  end

  assign mul_k = jump_mult(sel_in);

  always_comb begin
    for (int i = 0; i < NUM_LIMBS; i++) begin
      xa[i] = mul_in[32*i +: 32];
      ka[i] = mul_k[32*i +: 32];
    end
  end

  // Partial products, column order: 0 | 32 | 64 | 96
  always_comb begin
    pp_d[0] = 64'(xa[0]) * 64'(ka[0]);
    pp_d[1] = 64'(xa[0]) * 64'(ka[1]);
    pp_d[2] = 64'(xa[1]) * 64'(ka[0]);
    pp_d[3] = 64'(xa[0]) * 64'(ka[2]);
    pp_d[4] = 64'(xa[1]) * 64'(ka[1]);
    pp_d[5] = 64'(xa[2]) * 64'(ka[0]);
    pp_d[6] = 64'(xa[0]) * 64'(ka[3]);
    pp_d[7] = 64'(xa[1]) * 64'(ka[2]);
    pp_d[8] = 64'(xa[2]) * 64'(ka[1]);
    pp_d[9] = 64'(xa[3]) * 64'(ka[0]);
  end

  // Final add: shifted column sums plus the jump increment, mod 2^128
  assign head_d = 128'(g0_q)
                + (128'(g1_q) << 32)
                + (128'(g2_q) << 64)
                + {g3_q, 96'd0}
                + jump_inc(sel_g_q);

  assign lcg_adv = fill_active || gen_take;

  always_ff @(posedge clk_i) begin
    if (lcg_adv) begin
      for (int i = 0; i < NUM_PP; i++) begin
        pp_q[i] <= pp_d[i];
      end
      sel_p_q <= sel_in;
      g0_q    <= pp_q[0];
      g1_q    <= 65'(pp_q[1]) + 65'(pp_q[2]);
      g2_q    <= 66'(pp_q[3]) + 66'(pp_q[4]) + 66'(pp_q[5]);
      // only the low 32 bits of the top column survive the mod 2^128
      g3_q    <= pp_q[6][31:0] + pp_q[7][31:0] + pp_q[8][31:0] + pp_q[9][31:0];
      sel_g_q <= sel_p_q;
      head_q  <= head_d;
    end
  end

  // ---------------------------------------------------------------------
  // Request decode (single pass)
  // ---------------------------------------------------------------------
  assign req  = req_i.payload;
  assign code = req.control_present ? mod6(req.cmd_byte) : CODE_DATA;
  assign avail = (req.data_available > WORD_BYTES) ? WORD_BYTES : req.data_available;

  // XSL-RR output: xor halves, rotate right by top six state bits
  assign mix_word  = head_q[127:64] ^ head_q[63:0];
  assign mix_rot   = {mix_word, mix_word} >> head_q[127:122];
  assign gen_value = mix_rot[63:0];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      data_masked[8*b +: 8] = (4'(b) < avail) ? req.data_bytes[8*b +: 8] : 8'd0;
    end
  end

  always_comb begin
    rsp_new = '0;
    case (code)
      CODE_ZERO: rsp_new.value = '0;
      CODE_ONES: rsp_new.value = '1;
      CODE_HALF: rsp_new.value = VALUE_HALF;
      CODE_GEN: begin
        rsp_new.value          = gen_value;
        rsp_new.from_generator = 1'b1;
      end
      CODE_DATA, CODE_DATA_ALT: begin
        if (avail == 4'd0) begin
          // data stream exhausted: fall back to the generator
          rsp_new.value          = gen_value;
          rsp_new.from_generator = 1'b1;
        end else begin
          rsp_new.value       = data_masked;
          rsp_new.bytes_taken = avail;
        end
      end
      default: rsp_new.value = '0;
    endcase
  end

  assign req_i.ready = !skid_valid_q && !fill_active;
  assign in_fire     = req_i.valid && req_i.ready;
  assign gen_take    = in_fire && rsp_new.from_generator;

  // ---------------------------------------------------------------------
  // Response buffer: output register plus skid entry
  // ---------------------------------------------------------------------
  assign out_take = out_valid_q && rsp_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_take) begin
        out_d       = rsp_new;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = rsp_new;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // ---------------------------------------------------------------------
  // Seed register and refill counter
  // ---------------------------------------------------------------------
  always_comb begin
    fill_cnt_d = fill_cnt_q;
    if (seed_we_i) begin
      fill_cnt_d = FILL_CYCLES;
    end else if (fill_active) begin
      fill_cnt_d = fill_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q   <= FILL_CYCLES;
      seed_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      fill_cnt_q   <= fill_cnt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
    end
  end

endmodule

// ===== hw/rtl/cpvs_checker.sv =====
// Port-level assertions for the PCG64 value source, bound to the top level.
module cpvs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           seed_we_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input cpvs_pkg::rsp_t rsp_payload_i
);
  import cpvs_pkg::*;

  // stalled response beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("response beat dropped or changed while stalled");

  // generator beats never consume data bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.from_generator |-> rsp_payload_i.bytes_taken == 4'd0)
    else $error("generator beat reports data bytes taken");

  // no data and no generator: must be one of the constant values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.from_generator && rsp_payload_i.bytes_taken == 4'd0
    |-> rsp_payload_i.value == 64'd0 || rsp_payload_i.value == {64{1'b1}}
        || rsp_payload_i.value == VALUE_HALF)
    else $error("constant beat carries unexpected value");

  // seed write starts a refill, requests blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_we_i |=> !req_ready_i)
    else $error("request accepted during generator refill");

endmodule

bind controlled_pcg64_value_source_core cpvs_checker u_cpvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .seed_we_i     (seed_we_i),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the controlled PCG64 value source core.
`timescale 1ns / 100ps

module tb_top;
  import cpvs_pkg::*;

  // PCG64 XSL-RR recurrence constants for the predictor
  localparam logic [127:0] PCG_MULT = {64'h2360ed051fc65da4, 64'h4385df649fccf645};
  localparam logic [127:0] PCG_INC  = {64'h5851f42d4c957f2d, 64'h14057b7ef767814f};
  localparam int unsigned  OP_COUNT = 6;
  localparam int unsigned  PHASES   = 5;
  localparam int unsigned  PHASE_LEN = 310;

  // One directed vector: request fields, then the result typed in by hand
  // where it is obvious; rows with hand_checked low go through the predictor.
  typedef struct packed {
    logic        present;
    logic [7:0]  ctrl;
    logic [3:0]  avail;
    logic [63:0] data;
    logic        hand_checked;
    logic [63:0] value;
    logic [3:0]  taken;
    logic        gen;
  } vector_t;

  localparam int unsigned DIR_ROWS = 23;
  localparam vector_t DIRECTED [DIR_ROWS] = '{
    // first step right after reset, control absent and data exhausted
    '{1'b0, 8'hff, 4'd0, 64'h0, 1'b0, 64'h0, 4'd0, 1'b0},
    // absent control: control byte ignored, full word copied
    '{1'b0, 8'hff, 4'd8, 64'hffffffffffffffff,
      1'b1, 64'hffffffffffffffff, 4'd8, 1'b0},
    // single byte, upper bytes zero-filled
    '{1'b1, 8'h00, 4'd1, 64'hffffffffffffffff,
      1'b1, 64'h00000000000000ff, 4'd1, 1'b0},
    '{1'b1, 8'h01, 4'd8, 64'h0123456789abcdef, 1'b0, 64'h0, 4'd0, 1'b0},
    // constant codes ignore the data stream
    '{1'b1, 8'h02, 4'd8, 64'hffffffffffffffff, 1'b1, 64'h0, 4'd0, 1'b0},
    '{1'b1, 8'h03, 4'd0, 64'h0, 1'b1, 64'hffffffffffffffff, 4'd0, 1'b0},
    '{1'b1, 8'h04, 4'd3, 64'haaaaaaaaaaaaaaaa,
      1'b1, 64'h7fffffffffffffff, 4'd0, 1'b0},
    '{1'b1, 8'h05, 4'd7, 64'h0123456789abcdef,
      1'b1, 64'h0023456789abcdef, 4'd7, 1'b0},
    // top of the control byte range wraps through the modulo
    '{1'b1, 8'hff, 4'd8, 64'h0, 1'b1, 64'hffffffffffffffff, 4'd0, 1'b0},
    '{1'b1, 8'hfe, 4'd0, 64'h0, 1'b1, 64'h0, 4'd0, 1'b0},
    // oversized count clamps to a full word
    '{1'b1, 8'h06, 4'd15, 64'hdeadbeefcafef00d,
      1'b1, 64'hdeadbeefcafef00d, 4'd8, 1'b0},
    // alternate data code with no data left falls back to the generator
    '{1'b1, 8'h0b, 4'd0, 64'h5555555555555555, 1'b0, 64'h0, 4'd0, 1'b0},
    '{1'b1, 8'hfc, 4'd9, 64'h0, 1'b1, 64'h0, 4'd8, 1'b0},
    '{1'b1, 8'hfd, 4'd8, 64'hffffffffffffffff, 1'b0, 64'h0, 4'd0, 1'b0},
    '{1'b1, 8'h0a, 4'd8, 64'hffffffffffffffff,
      1'b1, 64'h7fffffffffffffff, 4'd0, 1'b0},
    '{1'b0, 8'h00, 4'd4, 64'h1122334455667788,
      1'b1, 64'h0000000055667788, 4'd4, 1'b0},
    '{1'b1, 8'h00, 4'd2, 64'h0, 1'b1, 64'h0, 4'd2, 1'b0},
    // consecutive generator steps
    '{1'b1, 8'h01, 4'd0, 64'h0, 1'b0, 64'h0, 4'd0, 1'b0},
    '{1'b1, 8'h07, 4'd0, 64'h0, 1'b0, 64'h0, 4'd0, 1'b0},
    '{1'b1, 8'hf9, 4'd5, 64'hffffffffffffffff,
      1'b1, 64'hffffffffffffffff, 4'd0, 1'b0},
    '{1'b0, 8'h00, 4'd0, 64'h0, 1'b0, 64'h0, 4'd0, 1'b0},
    '{1'b1, 8'h05, 4'd15, 64'h8000000000000001,
      1'b1, 64'h8000000000000001, 4'd8, 1'b0},
    '{1'b1, 8'h00, 4'd6, 64'hffffffffffffffff,
      1'b1, 64'h0000ffffffffffff, 4'd6, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        seed_we_i;
  logic [63:0] seed_i;

  cpvs_req_if req_bus ();
  cpvs_rsp_if rsp_bus ();

  controlled_pcg64_value_source_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (seed_we_i),
    .seed_i    (seed_i),
    .req_i     (req_bus),
    .rsp_o     (rsp_bus)
  );

  // Predictor state: 128-bit generator state plus outstanding results
  logic [127:0] pcg_state;
  rsp_t         pending_values [$];

  // Hand-typed expectation travels alongside the request beat it belongs to
  logic         beat_hand_checked;
  rsp_t         beat_hand_rsp;

  // Both sides run without gaps while this is set
  logic         smooth_flow;

  int unsigned  error_count;
  int unsigned  gen_beats;
  int unsigned  data_beats;
  int unsigned  const_beats;
  int unsigned  seed_writes;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // seed is zero-extended, added to the increment, then stepped once
  function automatic void reseed(logic [63:0] seed);
    pcg_state = {64'd0, seed} + PCG_INC;
    pcg_state = pcg_state * PCG_MULT + PCG_INC;
  endfunction

  // One LCG step, then xor-fold and rotate right by the top six state bits
  function automatic logic [63:0] pcg_next();
    logic [63:0] folded;
    logic [5:0]  rot;
    pcg_state = pcg_state * PCG_MULT + PCG_INC;
    rot       = pcg_state[127:122];
    folded    = pcg_state[127:64] ^ pcg_state[63:0];
    return (folded >> rot) | (folded << (7'd64 - {1'b0, rot}));
  endfunction

  function automatic rsp_t predict_value(req_t r);
    rsp_t       o;
    logic [2:0] code;
    logic [3:0] count;
    o     = '0;
    code  = r.control_present ? 3'(r.cmd_byte % OP_COUNT) : CODE_DATA;
    count = (r.data_available > WORD_BYTES) ? WORD_BYTES : r.data_available;
    case (code)
      CODE_ZERO: o.value = '0;
      CODE_ONES: o.value = '1;
      CODE_HALF: o.value = {1'b0, {63{1'b1}}};
      CODE_GEN: begin
        o.value          = pcg_next();
        o.from_generator = 1'b1;
      end
      default: begin
        // data codes: copy the low bytes, or step the generator when dry
        if (count == 4'd0) begin
          o.value          = pcg_next();
          o.from_generator = 1'b1;
        end else begin
          o.bytes_taken = count;
          for (int b = 0; b < 8; b++) begin
            if (b < count) o.value[8*b +: 8] = r.data_bytes[8*b +: 8];
          end
        end
      end
    endcase
    return o;
  endfunction

  // Mostly back-to-back, often a short gap, rarely a long one
  function automatic int pick_gap();
    int roll;
    if (smooth_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   roll;
    r.control_present = ($urandom_range(0, 9) != 0);
    r.cmd_byte        = 8'($urandom_range(0, 255));
    r.data_bytes      = {$urandom(), $urandom()};
    roll = $urandom_range(0, 99);
    if (roll < 12)      r.data_available = 4'd0;
    else if (roll < 80) r.data_available = 4'($urandom_range(1, 8));
    else if (roll < 90) r.data_available = WORD_BYTES;
    else                r.data_available = 4'($urandom_range(9, 15));
    return r;
  endfunction

  // Present one beat and hold it until the core takes it
  task automatic send_request(req_t r, logic hand_checked, rsp_t hand_rsp);
    req_bus.valid     <= 1'b1;
    req_bus.payload   <= r;
    beat_hand_checked <= hand_checked;
    beat_hand_rsp     <= hand_rsp;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic idle_sender(int cycles);
    req_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result, plus a little slack.
  // It waits for the scoreboard to log the last accepted beat first.
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_values.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Seed writes only land while the core is idle; the predictor follows
  task automatic write_seed(logic [63:0] seed);
    seed_we_i <= 1'b1;
    seed_i    <= seed;
    @(posedge clk_i);
    seed_we_i <= 1'b0;
    reseed(seed);
    seed_writes++;
  endtask

  // Scoreboard: predict on each accepted request, check each accepted response.
  // Request side first, so a same-edge response would still find its entry.
  always @(posedge clk_i) begin : scoreboard
    rsp_t predicted;
    rsp_t want;
    rsp_t got;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        predicted = predict_value(req_bus.payload);
        if (beat_hand_checked) predicted = beat_hand_rsp;
        if (predicted.from_generator)        gen_beats++;
        else if (predicted.bytes_taken != 0) data_beats++;
        else                                 const_beats++;
        pending_values.push_back(predicted);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = rsp_bus.payload;
        if (pending_values.size() == 0) begin
          $error("response beat with nothing expected: value %h", got.value);
          error_count++;
        end else begin
          want = pending_values.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, got.value);
            error_count++;
          end
          if (got.bytes_taken !== want.bytes_taken) begin
            $error("bytes_taken: expected %0d, got %0d", want.bytes_taken,
                   got.bytes_taken);
            error_count++;
          end
          if (got.from_generator !== want.from_generator) begin
            $error("from_generator: expected %0d, got %0d", want.from_generator,
                   got.from_generator);
            error_count++;
          end
        end
      end
    end
  end

  // Response side: ready bursts broken by stalls, none while smooth_flow is set
  initial begin : consumer
    int burst;
    int stall;
    forever begin
      burst = $urandom_range(1, 24);
      rsp_bus.ready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Stimulus: reset, directed table, then seeded random phases
  initial begin : stimulus
    req_t        r;
    rsp_t        hand;
    int          gap;
    logic [63:0] phase_seed;
    rst_ni            = 1'b0;
    seed_we_i         = 1'b0;
    seed_i            = '0;
    req_bus.valid     = 1'b0;
    req_bus.payload   = '0;
    beat_hand_checked = 1'b0;
    beat_hand_rsp     = '0;
    smooth_flow       = 1'b0;
    error_count       = 0;
    gen_beats         = 0;
    data_beats        = 0;
    const_beats       = 0;
    seed_writes       = 0;
    reseed('0);  // reset behaves as seed 0

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // core refills its LCG pipeline now; ready stays low until it is done

    foreach (DIRECTED[i]) begin
      r.control_present   = DIRECTED[i].present;
      r.cmd_byte          = DIRECTED[i].ctrl;
      r.data_available    = DIRECTED[i].avail;
      r.data_bytes        = DIRECTED[i].data;
      hand.value          = DIRECTED[i].value;
      hand.bytes_taken    = DIRECTED[i].taken;
      hand.from_generator = DIRECTED[i].gen;
      gap = pick_gap();
      if (gap > 0) idle_sender(gap);
      send_request(r, DIRECTED[i].hand_checked, hand);
    end
    drain();

    // Seeds: both extremes, then random and small values; phase 1 runs gapless
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_seed = '1;
        1:       phase_seed = '0;
        3:       phase_seed = 64'd1;
        default: phase_seed = {$urandom(), $urandom()};
      endcase
      write_seed(phase_seed);
      smooth_flow = (p == 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n == PHASE_LEN / 2) begin
          // hold off until the core has answered everything in flight
          req_bus.valid <= 1'b0;
          @(posedge clk_i);
          while (pending_values.size() != 0) @(posedge clk_i);
        end else begin
          gap = pick_gap();
          if (gap > 0) idle_sender(gap);
        end
        send_request(random_request(), 1'b0, '0);
      end
      drain();
      smooth_flow = 1'b0;
    end

    $display("Checked %0d generator, %0d data and %0d constant beats",
             gen_beats, data_beats, const_beats);
    $display("over %0d seed settings plus the reset seed", seed_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cpvs_pkg.sv
hw/rtl/cpvs_stream_if.sv
hw/rtl/controlled_pcg64_value_source_core.sv
hw/rtl/cpvs_checker.sv
verif/tb_top.sv
